// File: sv/rtpj_pkg.sv
`timescale 1ns / 1ps

package rtpj_pkg;

    // Register indexes on the configuration port (byte address 4*index).
    localparam int unsigned REG_INDEX_BITS = 3;
    localparam logic [REG_INDEX_BITS-1:0] REG_PAYLOAD_TYPE   = 3'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_SOURCE_ID      = 3'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_FRAME_WIDTH    = 3'd2;
    localparam logic [REG_INDEX_BITS-1:0] REG_FRAME_HEIGHT   = 3'd3;
    localparam logic [REG_INDEX_BITS-1:0] REG_TIMESTAMP_STEP = 3'd4;
    localparam logic [REG_INDEX_BITS-1:0] REG_PAYLOAD_LIMIT  = 3'd5;
    localparam int unsigned ADDR_BITS = REG_INDEX_BITS + 2;

    // Reset values of the registers.
    localparam logic [6:0]  RST_PAYLOAD_TYPE   = 7'd26;
    localparam logic [31:0] RST_SOURCE_ID      = 32'd0;
    localparam logic [10:0] RST_FRAME_WIDTH    = 11'd640;
    localparam logic [10:0] RST_FRAME_HEIGHT   = 11'd480;
    localparam logic [31:0] RST_TIMESTAMP_STEP = 32'd3000;
    localparam logic [13:0] RST_PAYLOAD_LIMIT  = 14'd1400;

    // Header constants.
    localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0]  JPEG_TSPEC_BYTE  = 8'h00;
    localparam logic [7:0]  JPEG_TYPE_BYTE   = 8'h01;
    localparam logic [7:0]  JPEG_Q_BYTE      = 8'hFF;
    localparam logic [13:0] LIMIT_CAP        = 14'd8192;
    localparam int unsigned HDR_BYTES        = 20;
    localparam int unsigned IDX_BITS         = $clog2(HDR_BYTES + 1);
    localparam logic [IDX_BITS-1:0] DATA_IDX = IDX_BITS'(HDR_BYTES);

    // Descriptor queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [6:0]  payload_type;
        logic [31:0] source_id;
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [31:0] timestamp_step;
        logic [13:0] payload_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        with_header;
        logic        marker;
        logic [15:0] seq_number;
        logic [31:0] timestamp;
        logic [23:0] offset;
        logic        packet_end;
    } desc_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

// File: sv/rtpj_regs.sv
`timescale 1ns / 1ps

module rtpj_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rtpj_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output rtpj_pkg::cfg_t                cfg
);
    import rtpj_pkg::*;

    cfg_t                      cfg_reg;
    logic [REG_INDEX_BITS-1:0] index;
    logic                      write_en;

    assign index    = paddr[ADDR_BITS-1:2];
    assign write_en = psel & penable & pwrite;
    assign pready   = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.payload_type   <= RST_PAYLOAD_TYPE;
            cfg_reg.source_id      <= RST_SOURCE_ID;
            cfg_reg.frame_width    <= RST_FRAME_WIDTH;
            cfg_reg.frame_height   <= RST_FRAME_HEIGHT;
            cfg_reg.timestamp_step <= RST_TIMESTAMP_STEP;
            cfg_reg.payload_limit  <= RST_PAYLOAD_LIMIT;
        end
        else if (write_en)
        begin
            unique case (index)
                REG_PAYLOAD_TYPE:   cfg_reg.payload_type   <= pwdata[6:0];
                REG_SOURCE_ID:      cfg_reg.source_id      <= pwdata;
                REG_FRAME_WIDTH:    cfg_reg.frame_width    <= pwdata[10:0];
                REG_FRAME_HEIGHT:   cfg_reg.frame_height   <= pwdata[10:0];
                REG_TIMESTAMP_STEP: cfg_reg.timestamp_step <= pwdata;
                REG_PAYLOAD_LIMIT:  cfg_reg.payload_limit  <= pwdata[13:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_PAYLOAD_TYPE:   prdata = {25'd0, cfg_reg.payload_type};
            REG_SOURCE_ID:      prdata = cfg_reg.source_id;
            REG_FRAME_WIDTH:    prdata = {21'd0, cfg_reg.frame_width};
            REG_FRAME_HEIGHT:   prdata = {21'd0, cfg_reg.frame_height};
            REG_TIMESTAMP_STEP: prdata = cfg_reg.timestamp_step;
            REG_PAYLOAD_LIMIT:  prdata = {18'd0, cfg_reg.payload_limit};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

// File: sv/rtpj_front.sv
`timescale 1ns / 1ps

module rtpj_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic [23:0]     frame_size,
    input  rtpj_pkg::cfg_t  cfg,
    output rtpj_pkg::desc_t desc
);
    import rtpj_pkg::*;

    logic [15:0] sequence_count_reg, sequence_count_next;
    logic [31:0] frame_timestamp_reg, frame_timestamp_next;
    logic [23:0] frame_offset_reg, frame_offset_next;
    logic [12:0] packet_fill_reg, packet_fill_next;

    logic [13:0] limit;
    logic [24:0] offset_inc;
    logic [23:0] remaining;
    logic [13:0] fill_inc;
    logic        frame_end;
    logic        packet_end;

    always_comb
    begin
        if (cfg.payload_limit == 14'd0)
            limit = 14'd1;
        else if (cfg.payload_limit > LIMIT_CAP)
            limit = LIMIT_CAP;
        else
            limit = cfg.payload_limit;
    end

    assign offset_inc = {1'b0, frame_offset_reg} + 25'd1;
    assign remaining  = (frame_size > frame_offset_reg) ? (frame_size - frame_offset_reg)
                                                        : 24'd1;
    assign fill_inc   = {1'b0, packet_fill_reg} + 14'd1;
    assign frame_end  = ({1'b0, frame_size} <= offset_inc);
    assign packet_end = frame_end || (fill_inc >= limit);

    always_comb
    begin
        desc.data_byte   = data_byte;
        desc.with_header = (packet_fill_reg == 13'd0);
        desc.marker      = (remaining <= {10'd0, limit});
        desc.seq_number  = sequence_count_reg;
        desc.timestamp   = frame_timestamp_reg;
        desc.offset      = frame_offset_reg;
        desc.packet_end  = packet_end;
    end

    always_comb
    begin
        sequence_count_next  = sequence_count_reg;
        frame_timestamp_next = frame_timestamp_reg;
        frame_offset_next    = frame_offset_reg;
        packet_fill_next     = packet_fill_reg;
        if (accept)
        begin
            if (packet_end)
            begin
                packet_fill_next    = 13'd0;
                sequence_count_next = sequence_count_reg + 16'd1;
            end
            else
            begin
                packet_fill_next = fill_inc[12:0];
            end
            if (frame_end)
            begin
                frame_offset_next    = 24'd0;
                frame_timestamp_next = frame_timestamp_reg + cfg.timestamp_step;
            end
            else
            begin
                frame_offset_next = offset_inc[23:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sequence_count_reg  <= 16'd0;
            frame_timestamp_reg <= 32'd0;
            frame_offset_reg    <= 24'd0;
            packet_fill_reg     <= 13'd0;
        end
        else
        begin
            sequence_count_reg  <= sequence_count_next;
            frame_timestamp_reg <= frame_timestamp_next;
            frame_offset_reg    <= frame_offset_next;
            packet_fill_reg     <= packet_fill_next;
        end
    end

endmodule

// File: sv/rtpj_queue.sv
`timescale 1ns / 1ps

module rtpj_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rtpj_pkg::desc_t        push_desc,
    input  logic                   pop,
    output rtpj_pkg::desc_t        head,
    output rtpj_pkg::queue_status_t status
);
    import rtpj_pkg::*;

    desc_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    assign head         = slot_reg[rd_ptr_reg];
    assign status.empty = (count_reg == QCNT_BITS'(0));
    assign status.full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/rtpj_back.sv
`timescale 1ns / 1ps

module rtpj_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  rtpj_pkg::cfg_t          cfg,
    input  rtpj_pkg::desc_t         head,
    input  rtpj_pkg::queue_status_t status,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              out_byte,
    output logic                    packet_first,
    output logic                    packet_last,
    output logic                    run_last
);
    import rtpj_pkg::*;

    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg;
    logic                packet_first_reg;
    logic                packet_last_reg;
    logic                run_last_reg;

    logic                load;
    logic                emit;
    logic                on_data;
    logic [7:0]          hdr_byte;
    logic [8:0]          width_blocks;
    logic [8:0]          height_blocks;

    assign load    = !out_valid_reg || !out_stall;
    assign emit    = load && !status.empty;
    assign on_data = !head.with_header || (idx_reg == DATA_IDX);
    assign pop     = emit && on_data;

    assign width_blocks  = 9'(({1'b0, cfg.frame_width} + 12'd7) >> 3);
    assign height_blocks = 9'(({1'b0, cfg.frame_height} + 12'd7) >> 3);

    always_comb
    begin
        case (idx_reg)
            5'd0:    hdr_byte = RTP_VERSION_BYTE;
            5'd1:    hdr_byte = {head.marker, cfg.payload_type};
            5'd2:    hdr_byte = head.seq_number[15:8];
            5'd3:    hdr_byte = head.seq_number[7:0];
            5'd4:    hdr_byte = head.timestamp[31:24];
            5'd5:    hdr_byte = head.timestamp[23:16];
            5'd6:    hdr_byte = head.timestamp[15:8];
            5'd7:    hdr_byte = head.timestamp[7:0];
            5'd8:    hdr_byte = cfg.source_id[31:24];
            5'd9:    hdr_byte = cfg.source_id[23:16];
            5'd10:   hdr_byte = cfg.source_id[15:8];
            5'd11:   hdr_byte = cfg.source_id[7:0];
            5'd12:   hdr_byte = JPEG_TSPEC_BYTE;
            5'd13:   hdr_byte = head.offset[23:16];
            5'd14:   hdr_byte = head.offset[15:8];
            5'd15:   hdr_byte = head.offset[7:0];
            5'd16:   hdr_byte = JPEG_TYPE_BYTE;
            5'd17:   hdr_byte = JPEG_Q_BYTE;
            5'd18:   hdr_byte = width_blocks[7:0];
            5'd19:   hdr_byte = height_blocks[7:0];
            default: hdr_byte = head.data_byte;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (emit)
            idx_next = on_data ? IDX_BITS'(0) : idx_reg + IDX_BITS'(1);
        out_valid_next = load ? !status.empty : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg     <= on_data ? head.data_byte : hdr_byte;
            packet_first_reg <= head.with_header && (idx_reg == IDX_BITS'(0));
            packet_last_reg  <= on_data && head.packet_end;
            run_last_reg     <= on_data;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign packet_first = packet_first_reg;
    assign packet_last  = packet_last_reg;
    assign run_last     = run_last_reg;

`ifndef SYNTHESIS
    // A header is only ever in progress while its descriptor is still queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != IDX_BITS'(0)) |-> !status.empty)
        else $error("header in progress with an empty queue");

    // The first header byte never closes a transaction run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && packet_first_reg) |-> !run_last_reg)
        else $error("packet_first together with run_last");

    // A packet can only end on a payload byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && packet_last_reg) |-> run_last_reg)
        else $error("packet_last on a header byte");

    // After a header byte is taken, the next transaction continues that header.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !run_last_reg) |=> out_valid_reg)
        else $error("header run broken off");
`endif

endmodule

// File: sv/rtp_jpeg_packetizer.sv
`timescale 1ns / 1ps

// Channel  | Handshake                 | Payload
// ---------+---------------------------+--------------------------------------------
// input    | in_valid / in_stall       | data_byte[7:0], frame_size[23:0]
// output   | out_valid / out_stall     | out_byte[7:0], packet_first, packet_last,
//          |                           | run_last
// config   | psel/penable/pwrite/pready| paddr[4:0], pwdata[31:0], prdata[31:0]
//
// A byte that continues a packet goes out alone; a byte that opens a packet goes out
// after the header, which the back end emits one header byte per cycle when not stalled.
// Sustained input rate is one byte per cycle inside a packet while out_stall is low.
// Reset clears the packet state and the descriptor queue and loads register defaults.
// in_stall rises only when the four-entry descriptor queue is full; out_stall holds
// the output register, and the queue keeps absorbing input meanwhile.

module rtp_jpeg_packetizer
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_byte,
    input  logic [23:0]                   frame_size,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    out_byte,
    output logic                          packet_first,
    output logic                          packet_last,
    output logic                          run_last,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rtpj_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rtpj_pkg::*;

    cfg_t          cfg;
    desc_t         front_desc;
    desc_t         head;
    queue_status_t status;
    logic          accept;
    logic          pop;

    // The input is held off only by a full queue, never by the output side directly.
    assign in_stall = status.full;
    assign accept   = in_valid && !status.full;

    // Register file behind the configuration port.
    rtpj_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The front end classifies each accepted byte: whether it opens a packet, the
    // marker bit, and the sequence, timestamp and offset that its header carries.
    // It advances the packet and frame counters at the same edge.
    rtpj_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .frame_size (frame_size),
        .cfg        (cfg),
        .desc       (front_desc)
    );

    // Short descriptor queue so the front keeps taking bytes while a header drains.
    rtpj_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_desc (front_desc),
        .pop       (pop),
        .head      (head),
        .status    (status)
    );

    // The back end expands the head descriptor into header and payload bytes and
    // owns the output register.
    rtpj_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (head),
        .status       (status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .packet_first (packet_first),
        .packet_last  (packet_last),
        .run_last     (run_last)
    );

endmodule
